### src/ctcgd_pkg.sv
// Shared types and constants of the CTC greedy decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ctcgd_pkg;

	localparam int SCORE_BITS   = 16;
	localparam int MAX_CLASSES  = 8192;
	localparam int MAX_STEPS    = 256;
	localparam int LABEL_BITS   = $clog2(MAX_CLASSES);
	localparam int DICT_BITS    = LABEL_BITS + 1;
	localparam int COUNT_BITS   = $clog2(MAX_STEPS + 1);
	localparam int TOTAL_BITS   = SCORE_BITS + COUNT_BITS;
	localparam int MAG_BITS     = TOTAL_BITS - 1;
	localparam int QUEUE_DEPTH  = 4;

	// configuration port
	localparam int DATA_BITS    = 32;
	localparam int ADDR_BITS    = 3;
	localparam int REG_IDX_BITS = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_DICT_SIZE = 1'b0;
	localparam logic [DICT_BITS-1:0]    DICT_RESET    = DICT_BITS'(MAX_CLASSES);

	// result kinds
	localparam logic KIND_LABEL   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// one decided time step, handed from front end to back end
	typedef struct packed {
		logic                         emit;
		logic                         seq_end;
		logic [LABEL_BITS-1:0]        label;
		logic signed [SCORE_BITS-1:0] score;
	} step_rec_t;

	typedef struct packed {
		logic                  start;
		logic [MAG_BITS-1:0]   dividend;
		logic [COUNT_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [MAG_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### src/ctcgd_front.sv
// Front end: running argmax over the class scores of a step, label decision.
// Depends on ctcgd_pkg.
`default_nettype none

module ctcgd_front
	import ctcgd_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic signed [SCORE_BITS-1:0] score,
	input  wire logic                         last_class,
	input  wire logic                         last_step,
	input  wire logic [DICT_BITS-1:0]         dict_size,
	output step_rec_t                         rec,
	output logic                              rec_push
);

	logic signed [SCORE_BITS-1:0] best_score_q;
	logic [LABEL_BITS-1:0]        best_index_q;
	logic [LABEL_BITS-1:0]        class_pos_q;
	logic [LABEL_BITS-1:0]        prev_label_q;
	logic                         first_step_q;

	logic                         take_new;
	logic signed [SCORE_BITS-1:0] new_score;
	logic [LABEL_BITS-1:0]        new_index;
	logic                         emit;

	// first class of a step always wins; later ones only when strictly greater
	assign take_new  = (class_pos_q == '0) || (score > best_score_q);
	assign new_score = take_new ? score : best_score_q;
	assign new_index = take_new ? class_pos_q : best_index_q;

	assign emit = (new_index != '0) && (first_step_q || (new_index != prev_label_q)) &&
		({1'b0, new_index} < dict_size);

	always_comb begin
		rec.emit    = emit;
		rec.seq_end = last_step;
		rec.label   = new_index;
		rec.score   = new_score;
	end

	assign rec_push = accept && last_class && (emit || last_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_index_q <= '0;
			class_pos_q  <= '0;
			prev_label_q <= '0;
			first_step_q <= 1'b1;
		end else if (accept) begin
			best_score_q <= new_score;
			best_index_q <= new_index;
			if (last_class) begin
				class_pos_q <= '0;
				if (last_step) begin
					prev_label_q <= '0;
					first_step_q <= 1'b1;
				end else begin
					prev_label_q <= new_index;
					first_step_q <= 1'b0;
				end
			end else if (class_pos_q != LABEL_BITS'(MAX_CLASSES - 1)) begin
				class_pos_q <= class_pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/ctcgd_queue.sv
// Short queue of decided steps between front end and back end.
// Depends on ctcgd_pkg.
`default_nettype none

module ctcgd_queue
	import ctcgd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire step_rec_t wr_data,
	input  wire logic      rd_en,
	output step_rec_t      rd_data,
	output logic           full,
	output logic           empty
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	step_rec_t             mem_q [DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full    = (cnt_q == CNT_BITS'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/ctcgd_div.sv
// Restoring divider, one quotient bit per cycle, for the sequence mean.
// Depends on ctcgd_pkg.
`default_nettype none

module ctcgd_div
	import ctcgd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int STEP_BITS = $clog2(MAG_BITS + 1);

	logic                  busy_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [MAG_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[MAG_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_comb begin
		rsp.done     = !busy_q;
		rsp.quotient = quo_q;
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_BITS-2:0], fits};
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : COUNT_BITS'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= STEP_BITS'(MAG_BITS);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/ctcgd_back.sv
// Back end: score totals, result register and the end-of-sequence summary.
// Depends on ctcgd_pkg and ctcgd_div.
`default_nettype none

module ctcgd_back
	import ctcgd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire step_rec_t                     rec,
	input  wire logic                          rec_empty,
	output logic                               rec_pop,
	input  wire logic                          pop,
	output logic                               empty,
	output logic                               kind,
	output logic [LABEL_BITS-1:0]              label,
	output logic signed [SCORE_BITS-1:0]       label_score,
	output logic signed [SCORE_BITS-1:0]       mean_score,
	output logic [COUNT_BITS-1:0]              label_count,
	output logic                               last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_SUM  = 2'd3;

	logic [1:0]                    state_q;
	logic [1:0]                    state_d;
	logic signed [TOTAL_BITS-1:0]  total_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic                          neg_q;
	logic                          none_q;

	logic                          out_valid_q;
	logic                          out_kind_q;
	logic [LABEL_BITS-1:0]         out_label_q;
	logic signed [SCORE_BITS-1:0]  out_lscore_q;
	logic signed [SCORE_BITS-1:0]  out_mean_q;
	logic [COUNT_BITS-1:0]         out_count_q;
	logic                          out_last_q;

	logic                          slot_free;
	logic                          load_label;
	logic                          load_sum;
	logic                          clear_seq;
	logic signed [TOTAL_BITS-1:0]  total_abs;
	logic [MAG_BITS-1:0]           signed_quo;
	logic signed [SCORE_BITS-1:0]  mean;
	div_req_t                      div_req;
	div_rsp_t                      div_rsp;

	ctcgd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign slot_free  = !out_valid_q || pop;
	assign total_abs  = total_q[TOTAL_BITS-1] ? -total_q : total_q;
	assign signed_quo = neg_q ? -div_rsp.quotient : div_rsp.quotient;
	assign mean       = none_q ? '0 : SCORE_BITS'(signed_quo);

	always_comb begin
		div_req.start    = (state_q == ST_LOAD);
		div_req.dividend = MAG_BITS'(total_abs);
		div_req.divisor  = count_q;
	end

	always_comb begin
		state_d    = state_q;
		rec_pop    = 1'b0;
		load_label = 1'b0;
		load_sum   = 1'b0;
		clear_seq  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!rec_empty) begin
					if (rec.emit) begin
						if (slot_free) begin
							rec_pop    = 1'b1;
							load_label = 1'b1;
							if (rec.seq_end) begin
								state_d = ST_LOAD;
							end
						end
					end else begin
						// a record without a label only ends the sequence
						rec_pop = 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (slot_free) begin
					load_sum  = 1'b1;
					clear_seq = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clear_seq) begin
				total_q <= '0;
				count_q <= '0;
			end else if (load_label && (count_q < COUNT_BITS'(MAX_STEPS))) begin
				total_q <= total_q + TOTAL_BITS'(rec.score);
				count_q <= count_q + 1'b1;
			end
			if (load_label || load_sum) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			neg_q  <= total_q[TOTAL_BITS-1];
			none_q <= (count_q == '0);
		end
		if (load_label) begin
			out_kind_q   <= KIND_LABEL;
			out_label_q  <= rec.label;
			out_lscore_q <= rec.score;
			out_mean_q   <= '0;
			out_count_q  <= '0;
			out_last_q   <= !rec.seq_end;
		end else if (load_sum) begin
			out_kind_q   <= KIND_SUMMARY;
			out_label_q  <= '0;
			out_lscore_q <= '0;
			out_mean_q   <= mean;
			out_count_q  <= count_q;
			out_last_q   <= 1'b1;
		end
	end

	assign empty       = !out_valid_q;
	assign kind        = out_kind_q;
	assign label       = out_label_q;
	assign label_score = out_lscore_q;
	assign mean_score  = out_mean_q;
	assign label_count = out_count_q;
	assign last        = out_last_q;

endmodule

`default_nettype wire

### src/ctc_greedy_decoder.sv
// Top level of the CTC greedy decoder: front end, step queue, back end, register.
// Depends on ctcgd_pkg, ctcgd_front, ctcgd_queue and ctcgd_back.
`default_nettype none

//  channel   | direction | handshake            | words
//  ----------+-----------+----------------------+----------------------------------------
//  score in  | in        | push / full          | score, last_class, last_step
//  result    | out       | empty / pop          | kind, label, label_score, mean_score,
//            |           |                      | label_count, last
//  register  | in / out  | psel/penable/pready  | dictionary_size at byte address 0
//
//  One score word is taken each cycle unless full; the front end's argmax needs no more.
//  A step word passes from the step queue into the result register when the back end is idle
//  and the result register is free. A sequence end holds the back end in its load, divide and
//  summary states while the one-bit-per-cycle divider runs; the step queue absorbs that.
//  A stalled result holds its words; push proceeds until the step queue fills, then full rises.
//  Reset clears all control state and sets dictionary_size to 8192; no clearing pass.

module ctc_greedy_decoder
	import ctcgd_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_BITS-1:0]          paddr,
	input  wire logic [DATA_BITS-1:0]          pwdata,
	output logic [DATA_BITS-1:0]               prdata,
	output logic                               pready,
	// scores
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [SCORE_BITS-1:0]  score,
	input  wire logic                          last_class,
	input  wire logic                          last_step,
	// results
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               kind,
	output logic [LABEL_BITS-1:0]              label,
	output logic signed [SCORE_BITS-1:0]       label_score,
	output logic signed [SCORE_BITS-1:0]       mean_score,
	output logic [COUNT_BITS-1:0]              label_count,
	output logic                               last
);

	logic [DICT_BITS-1:0] dict_size_q;
	logic                 accept;
	logic                 rec_push;
	logic                 rec_pop;
	logic                 rec_empty;
	step_rec_t            front_rec;
	step_rec_t            head_rec;
	logic                 reg_sel;

	// register port: always ready, one register at index zero, others ignored
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_BITS-1 -: REG_IDX_BITS] == REG_DICT_SIZE);
	assign prdata  = reg_sel ? DATA_BITS'(dict_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_size_q <= DICT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			dict_size_q <= pwdata[DICT_BITS-1:0];
		end
	end

	// take a score word whenever the step queue has room
	assign accept = push && !full;

	ctcgd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.score      (score),
		.last_class (last_class),
		.last_step  (last_step),
		.dict_size  (dict_size_q),
		.rec        (front_rec),
		.rec_push   (rec_push)
	);

	ctcgd_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (front_rec),
		.rd_en   (rec_pop),
		.rd_data (head_rec),
		.full    (full),
		.empty   (rec_empty)
	);

	ctcgd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec         (head_rec),
		.rec_empty   (rec_empty),
		.rec_pop     (rec_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.label       (label),
		.label_score (label_score),
		.mean_score  (mean_score),
		.label_count (label_count),
		.last        (last)
	);

endmodule

`default_nettype wire

### src/ctcgd_chk.sv
// Port-level checks of the CTC greedy decoder, bound to the top level.
// Depends on ctcgd_pkg and ctc_greedy_decoder.
`default_nettype none

module ctcgd_chk
	import ctcgd_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic                         kind,
	input wire logic [LABEL_BITS-1:0]        label,
	input wire logic signed [SCORE_BITS-1:0] label_score,
	input wire logic signed [SCORE_BITS-1:0] mean_score,
	input wire logic [COUNT_BITS-1:0]        label_count,
	input wire logic                         last
);

	// a waiting word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty &&
		$stable({kind, label, label_score, mean_score, label_count, last}))
		else $error("result word changed while waiting");

	// label words carry a real label and no summary fields
	a_label: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == KIND_LABEL) |->
		(label != '0) && (mean_score == '0) && (label_count == '0))
		else $error("malformed label word");

	// summary words close the item and stay within the count limit
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (kind == KIND_SUMMARY) |->
		last && (label == '0) && (label_score == '0) &&
		(label_count <= COUNT_BITS'(MAX_STEPS)))
		else $error("malformed summary word");

	// nothing waits straight after reset
	a_reset: assert property (@(posedge clk) $rose(arst_n) |-> empty)
		else $error("result present after reset");

endmodule

bind ctc_greedy_decoder ctcgd_chk u_ctcgd_chk (.*);

`default_nettype wire
